// ===== rtl/esd_pkg.sv =====
// Shared types and character constants for the escape sequence byte decoder.
package esd_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_DIGIT  = 3'd2,
        MODE_ZERO   = 3'd3,
        MODE_ZERO2  = 3'd4
    } mode_t;

    // Decoded bytes of one character: up to three, in slot order.
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } res_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_V   = 8'h76;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;

endpackage

// ===== rtl/esd_if.sv =====
// Handshake channels for raw characters and decoded bytes.
interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_text;

    modport source (output valid, output char_in, output end_of_text, input ready);
    modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       run_last;

    modport source (output valid, output byte_out, output run_last, input ready);
    modport sink (input valid, input byte_out, input run_last, output ready);
endinterface

// ===== rtl/esd_front.sv =====
// Front end: accepts characters, tracks escape state, builds decoded byte groups.
module esd_front
(
    input  logic            clk,
    input  logic            rst_n,
    esd_in_if.sink          char_ch,
    input  logic            full,
    output logic            push,
    output esd_pkg::res_t   push_data
);

    function automatic logic is_dec(input logic [7:0] c);
        is_dec = (c >= esd_pkg::CH_ZERO) && (c <= esd_pkg::CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = is_dec(c)
              || ((c >= esd_pkg::CH_UPPER_A) && (c <= esd_pkg::CH_UPPER_F))
              || ((c >= esd_pkg::CH_LOWER_A) && (c <= esd_pkg::CH_LOWER_F));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (is_dec(c))
            d = c - esd_pkg::CH_ZERO;
        else if ((c >= esd_pkg::CH_UPPER_A) && (c <= esd_pkg::CH_UPPER_F))
            d = c - esd_pkg::CH_UPPER_A + 8'd10;
        else if ((c >= esd_pkg::CH_LOWER_A) && (c <= esd_pkg::CH_LOWER_F))
            d = c - esd_pkg::CH_LOWER_A + 8'd10;
        hex_val = d[3:0];
    endfunction

    // Control letter after a backslash: {known, byte}.
    function automatic logic [8:0] ctrl_code(input logic [7:0] c);
        case (c)
            esd_pkg::CH_LOWER_A:   ctrl_code = {1'b1, esd_pkg::CH_BEL};
            esd_pkg::CH_LOWER_B:   ctrl_code = {1'b1, esd_pkg::CH_BS};
            esd_pkg::CH_LOWER_T:   ctrl_code = {1'b1, esd_pkg::CH_TAB};
            esd_pkg::CH_LOWER_N:   ctrl_code = {1'b1, esd_pkg::CH_LF};
            esd_pkg::CH_LOWER_V:   ctrl_code = {1'b1, esd_pkg::CH_VT};
            esd_pkg::CH_LOWER_F:   ctrl_code = {1'b1, esd_pkg::CH_FF};
            esd_pkg::CH_LOWER_R:   ctrl_code = {1'b1, esd_pkg::CH_CR};
            esd_pkg::CH_BACKSLASH: ctrl_code = {1'b1, esd_pkg::CH_BACKSLASH};
            default:               ctrl_code = {1'b0, esd_pkg::CH_NUL};
        endcase
    endfunction

    esd_pkg::mode_t mode_reg;
    esd_pkg::mode_t mode_next;
    logic [7:0]     held_reg;
    logic [7:0]     held_next;

    esd_pkg::mode_t  fmode;
    logic [7:0]      fheld;
    logic [2:0][7:0] fb;
    logic [1:0]      fcnt;
    logic [1:0][7:0] lb;
    logic [1:0]      lcnt;
    logic [2:0]      total;
    logic            accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= esd_pkg::MODE_NORMAL;
            held_reg <= 8'h00;
        end
        else
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

    always_comb
    begin
        logic [7:0]      c;
        logic [8:0]      cc;
        logic [2:0][7:0] ob;
        c     = char_ch.char_in;
        cc    = ctrl_code(c);
        fmode = esd_pkg::MODE_NORMAL;
        fheld = held_reg;
        fb    = '0;
        fcnt  = 2'd0;

        // Decode the character against the current escape state.
        case (mode_reg)
            esd_pkg::MODE_ESC:
            begin
                if (c == esd_pkg::CH_ZERO)
                    fmode = esd_pkg::MODE_ZERO;
                else if (is_dec(c))
                begin
                    fheld = c;
                    fmode = esd_pkg::MODE_DIGIT;
                end
                else if (cc[8])
                begin
                    fb[0] = cc[7:0];
                    fcnt  = 2'd1;
                end
                else
                begin
                    fb[0] = esd_pkg::CH_BACKSLASH;
                    fb[1] = c;
                    fcnt  = 2'd2;
                end
            end
            esd_pkg::MODE_DIGIT:
            begin
                if (is_hex(c))
                begin
                    fb[0] = {hex_val(held_reg), hex_val(c)};
                    fcnt  = 2'd1;
                end
                else
                begin
                    fb[0] = {4'h0, hex_val(held_reg)};
                    fb[1] = c;
                    if (c == esd_pkg::CH_BACKSLASH)
                    begin
                        fmode = esd_pkg::MODE_ESC;
                        fcnt  = 2'd1;
                    end
                    else
                        fcnt = 2'd2;
                end
            end
            esd_pkg::MODE_ZERO:
            begin
                fheld = c;
                fmode = esd_pkg::MODE_ZERO2;
            end
            esd_pkg::MODE_ZERO2:
            begin
                if (is_hex(c))
                begin
                    fb[0] = is_hex(held_reg) ? {hex_val(held_reg), hex_val(c)}
                                             : esd_pkg::CH_BACKSLASH;
                    fcnt  = 2'd1;
                end
                else if (is_hex(held_reg))
                begin
                    fb[0] = {4'h0, hex_val(held_reg)};
                    fb[1] = c;
                    if (c == esd_pkg::CH_BACKSLASH)
                    begin
                        fmode = esd_pkg::MODE_ESC;
                        fcnt  = 2'd1;
                    end
                    else
                        fcnt = 2'd2;
                end
                else if (held_reg == esd_pkg::CH_BACKSLASH)
                begin
                    // Held backslash opens a new escape that c completes.
                    fb[0] = esd_pkg::CH_NUL;
                    if (cc[8])
                    begin
                        fb[1] = cc[7:0];
                        fcnt  = 2'd2;
                    end
                    else
                    begin
                        fb[1] = esd_pkg::CH_BACKSLASH;
                        fb[2] = c;
                        fcnt  = 2'd3;
                    end
                end
                else
                begin
                    fb[0] = esd_pkg::CH_NUL;
                    fb[1] = held_reg;
                    fb[2] = c;
                    if (c == esd_pkg::CH_BACKSLASH)
                    begin
                        fmode = esd_pkg::MODE_ESC;
                        fcnt  = 2'd2;
                    end
                    else
                        fcnt = 2'd3;
                end
            end
            default:
            begin
                if (c == esd_pkg::CH_BACKSLASH)
                    fmode = esd_pkg::MODE_ESC;
                else
                begin
                    fb[0] = c;
                    fcnt  = 2'd1;
                end
            end
        endcase

        // Flush bytes of whatever escape is left open at end of text.
        lb   = '0;
        lcnt = 2'd0;
        if (char_ch.end_of_text)
        begin
            case (fmode)
                esd_pkg::MODE_ESC:
                begin
                    lb[0] = esd_pkg::CH_BACKSLASH;
                    lcnt  = 2'd1;
                end
                esd_pkg::MODE_DIGIT:
                begin
                    lb[0] = {4'h0, hex_val(fheld)};
                    lcnt  = 2'd1;
                end
                esd_pkg::MODE_ZERO:
                begin
                    lb[0] = esd_pkg::CH_NUL;
                    lcnt  = 2'd1;
                end
                esd_pkg::MODE_ZERO2:
                begin
                    if (is_hex(fheld))
                    begin
                        lb[0] = {4'h0, hex_val(fheld)};
                        lcnt  = 2'd1;
                    end
                    else
                    begin
                        lb[0] = esd_pkg::CH_NUL;
                        lb[1] = fheld;
                        lcnt  = 2'd2;
                    end
                end
                default:
                begin
                    lcnt = 2'd0;
                end
            endcase
        end

        // Append flush bytes after decode bytes; drop anything past three.
        ob = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < fcnt)
                ob[k] = fb[k];
            else if ((3'(k) - {1'b0, fcnt}) < {1'b0, lcnt})
                ob[k] = lb[1'(3'(k) - {1'b0, fcnt})];
        end
        total = {1'b0, fcnt} + {1'b0, lcnt};
        push_data.bytes = ob;
        push_data.count = (total > 3'd3) ? 2'd3 : total[1:0];

        accept        = char_ch.valid && char_ch.ready;
        push          = accept && (total != 3'd0);
        mode_next     = mode_reg;
        held_next     = held_reg;
        if (accept)
        begin
            mode_next = char_ch.end_of_text ? esd_pkg::MODE_NORMAL : fmode;
            held_next = fheld;
        end
    end

    assign char_ch.ready = !full;

endmodule

// ===== rtl/esd_fifo.sv =====
// Queue of decoded byte groups between front end and back end.
module esd_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  esd_pkg::res_t push_data,
    output logic          full,
    input  logic          pop,
    output esd_pkg::res_t pop_data,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    esd_pkg::res_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push_ok;
    logic          pop_ok;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign push_ok  = push && !full;
    assign pop_ok   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop_ok)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push_ok && !pop_ok)
            count_next = count_reg + 1'b1;
        else if (pop_ok && !push_ok)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
            mem_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count above depth");

    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !pop) |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("queue fill count lost a write");

    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("back end popped an empty queue");
`endif

endmodule

// ===== rtl/esd_back.sv =====
// Back end: streams each queued byte group out one beat at a time.
module esd_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  esd_pkg::res_t head,
    input  logic          empty,
    output logic          pop,
    esd_out_if.source     byte_ch
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       last;
    logic       fire;

    assign last = (idx_reg == (head.count - 2'd1));
    assign fire = byte_ch.valid && byte_ch.ready;
    assign pop  = fire && last;

    assign byte_ch.valid    = !empty;
    assign byte_ch.run_last = last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    byte_ch.byte_out = head.bytes[0];
            2'd1:    byte_ch.byte_out = head.bytes[1];
            2'd2:    byte_ch.byte_out = head.bytes[2];
            default: byte_ch.byte_out = head.bytes[0];
        endcase

        idx_next = idx_reg;
        if (fire)
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

// ===== rtl/escape_sequence_byte_decoder.sv =====
// A character's bytes are written into the group queue and offered when they reach its head.
// One character in per cycle while the queue has room; one byte out per cycle while ready.
// A character that decodes to n bytes (0 to 3) leaves as n beats on the output side.
// The queue of QUEUE_DEPTH groups sets how long input keeps flowing while output stalls.
// Reset (rst_n low, asynchronous): escape state returns to pass-through, queue empties.
module escape_sequence_byte_decoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    esd_in_if.sink    char_ch,
    esd_out_if.source byte_ch
);

    // Front end to queue: one entry per character that yields bytes.
    logic          push;
    esd_pkg::res_t push_data;
    logic          full;

    // Queue to back end: head group, popped after its last beat leaves.
    logic          pop;
    esd_pkg::res_t head;
    logic          empty;

    // Classify each character and fold in end-of-text flush bytes.
    esd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_ch   (char_ch),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple input rate from output stalls.
    esd_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty)
    );

    // Serialize each group into beats and mark the group's last byte.
    esd_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .empty   (empty),
        .pop     (pop),
        .byte_ch (byte_ch)
    );

endmodule
